FILE: rtl/message_deframer_macros.svh
// ---------------------------------------------------------------------------
// message deframer assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef MESSAGE_DEFRAMER_MACROS_SVH
`define MESSAGE_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define MDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("message deframer check failed");
// antecedent holds -> consequent holds in the next cycle
`define MDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("message deframer check failed");
`else
`define MDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/mdf_pkg.sv
// ---------------------------------------------------------------------------
// mdf_pkg
// shared types, codes and character constants of the message deframer
// ---------------------------------------------------------------------------
package mdf_pkg;

    localparam int LENGTH_BITS_DEFAULT = 24;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int PREFIX_LEN          = 15;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // header prefix in lower case, first character in the top byte
    localparam logic [8*PREFIX_LEN-1:0] PREFIX_LC = "content-length:";

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_INPUT      = 3'd1,
        ERR_NO_LENGTH  = 3'd2,
        ERR_TOO_LARGE  = 3'd3,
        ERR_EMPTY_BODY = 3'd4
    } err_code_t;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_MATCHED = 3'd1,
        PH_BLANKS  = 3'd2,
        PH_DIGITS  = 3'd3,
        PH_IGNORE  = 3'd4
    } header_phase_t;

    // one classified input beat
    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic       is_blank;
        logic [7:0] lc;
        logic [3:0] digit;
    } item_t;

    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [3:0] idx;
        idx = 4'(PREFIX_LEN - 1) - pos;
        if (pos < 4'(PREFIX_LEN))
            return PREFIX_LC[8*idx +: 8];
        else
            return 8'h00;
    endfunction

endpackage

FILE: rtl/mdf_ifs.sv
// ---------------------------------------------------------------------------
// message deframer channels
// byte stream in, result stream out and the mode write channel
// ---------------------------------------------------------------------------
interface mdf_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, data_byte, end_of_input, input ready);
    modport sink   (input valid, data_byte, end_of_input, output ready);
endinterface

interface mdf_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       end_of_message;
    logic       is_error;
    logic [2:0] error_code;

    modport source (output valid, payload_byte, end_of_message, is_error, error_code,
                    input ready);
    modport sink   (input valid, payload_byte, end_of_message, is_error, error_code,
                    output ready);
endinterface

interface mdf_cfg_if;
    logic valid;
    logic ready;
    logic framing_mode;

    modport source (output valid, framing_mode, input ready);
    modport sink   (input valid, framing_mode, output ready);
endinterface

FILE: rtl/mdf_front.sv
// ---------------------------------------------------------------------------
// mdf_front
// accepts stream beats and classifies each byte for the engine
// ---------------------------------------------------------------------------
module mdf_front
    import mdf_pkg::*;
(
    mdf_stream_if.sink stream,
    input  logic       q_full,
    output logic       push,
    output item_t      push_item
);

    logic [7:0] b;

    assign b            = stream.data_byte;
    assign stream.ready = !q_full;
    assign push         = stream.valid && !q_full;

    always_comb
    begin
        push_item.data     = b;
        push_item.eoi      = stream.end_of_input;
        push_item.is_cr    = (b == CH_CR);
        push_item.is_lf    = (b == CH_LF);
        push_item.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        push_item.is_blank = (b == CH_SPACE) || (b == CH_TAB);
        push_item.lc       = ((b >= CH_UC_A) && (b <= CH_UC_Z)) ? (b | CASE_BIT) : b;
        push_item.digit    = 4'(b - CH_ZERO);
    end

endmodule

FILE: rtl/mdf_queue.sv
// ---------------------------------------------------------------------------
// mdf_queue
// short fifo of classified beats between front and engine
// ---------------------------------------------------------------------------
`include "message_deframer_macros.svh"

module mdf_queue
    import mdf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  flush,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  not_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (flush)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    `MDF_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, count_reg != '0)
    `MDF_ASSERT_IMP(a_q_bounded, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

FILE: rtl/mdf_engine.sv
// ---------------------------------------------------------------------------
// mdf_engine
// line, header and body tracking; while the result side is not stalled, one classified beat per cycle
// ---------------------------------------------------------------------------
`include "message_deframer_macros.svh"

module mdf_engine
    import mdf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_mode,
    input  logic item_valid,
    input  item_t item,
    output logic item_pop,
    mdf_result_if.source result
);

    localparam int XW = LENGTH_BITS + 4;

    logic                   mode_reg;
    logic                   in_body_reg, in_body_next;
    logic                   pending_cr_reg, pending_cr_next;
    logic                   line_has_reg, line_has_next;
    logic [3:0]             pos_reg, pos_next;
    header_phase_t          phase_reg, phase_next;
    logic                   seen_reg, seen_next;
    logic                   ovf_reg, ovf_next;
    logic [LENGTH_BITS-1:0] decl_reg, decl_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [7:0]             held_reg, held_next;
    logic                   held_valid_reg, held_valid_next;

    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_eom_reg;
    err_code_t              out_code_reg;

    logic                   res_valid;
    logic [7:0]             res_byte;
    logic                   res_eom;
    err_code_t              res_code;

    logic                   clr_msg;
    logic                   clr_line;
    logic                   skip_lf;
    logic [XW-1:0]          len_x10;
    logic                   len_big;
    logic [LENGTH_BITS-1:0] rem_dec;

    assign item_pop = item_valid && (!out_valid_reg || result.ready);

    // running length times ten plus the new digit
    assign len_x10 = ({4'b0, decl_reg} << 3) + ({4'b0, decl_reg} << 1)
                   + {{LENGTH_BITS{1'b0}}, item.digit};
    assign len_big = (len_x10[XW-1:LENGTH_BITS] != 4'b0);
    assign rem_dec = rem_reg - 1'b1;
    assign skip_lf = pending_cr_reg && item.is_lf;

    always_comb
    begin
        in_body_next    = in_body_reg;
        pending_cr_next = pending_cr_reg;
        line_has_next   = line_has_reg;
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        seen_next       = seen_reg;
        ovf_next        = ovf_reg;
        decl_next       = decl_reg;
        rem_next        = rem_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        res_valid       = 1'b0;
        res_byte        = 8'h00;
        res_eom         = 1'b0;
        res_code        = ERR_NONE;
        clr_msg         = 1'b0;
        clr_line        = 1'b0;

        if (item_pop)
        begin
            if (item.eoi)
            begin
                held_valid_next = 1'b0;
                held_next       = 8'h00;
                pending_cr_next = 1'b0;
                clr_msg         = 1'b0 | 1'b1;
                res_valid       = 1'b1;
                res_code        = ERR_INPUT;
            end
            else
            begin
                pending_cr_next = 1'b0;
                if (skip_lf)
                begin
                    // lf of a cr lf pair
                end
                else if (!mode_reg)
                begin
                    if (item.is_cr || item.is_lf)
                    begin
                        pending_cr_next = item.is_cr;
                        res_valid       = 1'b1;
                        if (held_valid_reg)
                        begin
                            held_valid_next = 1'b0;
                            res_byte        = held_reg;
                            res_eom         = 1'b1;
                        end
                        else
                            res_code = ERR_INPUT;
                    end
                    else
                    begin
                        held_next       = item.data;
                        held_valid_next = 1'b1;
                        if (held_valid_reg)
                        begin
                            res_valid = 1'b1;
                            res_byte  = held_reg;
                        end
                    end
                end
                else if (in_body_reg)
                begin
                    rem_next  = rem_dec;
                    res_valid = 1'b1;
                    res_byte  = item.data;
                    if (rem_dec == '0)
                    begin
                        clr_msg = 1'b1;
                        res_eom = 1'b1;
                    end
                end
                else if (item.is_cr || item.is_lf)
                begin
                    pending_cr_next = item.is_cr;
                    priority if (line_has_reg)
                        clr_line = 1'b1;
                    else if (!seen_reg)
                    begin
                        clr_msg   = 1'b1;
                        res_valid = 1'b1;
                        res_code  = ERR_NO_LENGTH;
                    end
                    else if (ovf_reg)
                    begin
                        clr_msg   = 1'b1;
                        res_valid = 1'b1;
                        res_code  = ERR_TOO_LARGE;
                    end
                    else if (decl_reg == '0)
                    begin
                        clr_msg   = 1'b1;
                        res_valid = 1'b1;
                        res_code  = ERR_EMPTY_BODY;
                    end
                    else
                    begin
                        clr_line     = 1'b1;
                        in_body_next = 1'b1;
                        rem_next     = decl_reg;
                    end
                end
                else
                begin
                    line_has_next = 1'b1;
                    unique case (phase_reg)
                        PH_PREFIX:
                        begin
                            if (pos_reg < 4'(PREFIX_LEN) && item.lc == prefix_char(pos_reg))
                            begin
                                pos_next = pos_reg + 1'b1;
                                if (pos_reg == 4'(PREFIX_LEN - 1))
                                    phase_next = PH_MATCHED;
                            end
                            else
                                phase_next = PH_IGNORE;
                        end
                        PH_MATCHED:
                        begin
                            // length header found: restart the length
                            seen_next = 1'b1;
                            ovf_next  = 1'b0;
                            if (item.is_blank)
                            begin
                                decl_next  = '0;
                                phase_next = PH_BLANKS;
                            end
                            else if (item.is_digit)
                            begin
                                decl_next  = {{(LENGTH_BITS-4){1'b0}}, item.digit};
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                decl_next  = '0;
                                phase_next = PH_IGNORE;
                            end
                        end
                        PH_BLANKS, PH_DIGITS:
                        begin
                            if (phase_reg == PH_BLANKS && item.is_blank)
                                phase_next = PH_BLANKS;
                            else if (item.is_digit)
                            begin
                                phase_next = PH_DIGITS;
                                if (!ovf_reg)
                                begin
                                    if (len_big)
                                        ovf_next = 1'b1;
                                    else
                                        decl_next = len_x10[LENGTH_BITS-1:0];
                                end
                            end
                            else
                                phase_next = PH_IGNORE;
                        end
                        default:
                            phase_next = PH_IGNORE;
                    endcase
                end
            end
        end

        if (clr_msg)
        begin
            in_body_next = 1'b0;
            seen_next    = 1'b0;
            ovf_next     = 1'b0;
            decl_next    = '0;
            rem_next     = '0;
        end
        if (clr_msg || clr_line)
        begin
            line_has_next = 1'b0;
            pos_next      = 4'd0;
            phase_next    = PH_PREFIX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            in_body_reg    <= 1'b0;
            pending_cr_reg <= 1'b0;
            line_has_reg   <= 1'b0;
            pos_reg        <= 4'd0;
            phase_reg      <= PH_PREFIX;
            seen_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            decl_reg       <= '0;
            rem_reg        <= '0;
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg       <= cfg_mode;
            in_body_reg    <= 1'b0;
            pending_cr_reg <= 1'b0;
            line_has_reg   <= 1'b0;
            pos_reg        <= 4'd0;
            phase_reg      <= PH_PREFIX;
            seen_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            decl_reg       <= '0;
            rem_reg        <= '0;
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_body_reg    <= in_body_next;
            pending_cr_reg <= pending_cr_next;
            line_has_reg   <= line_has_next;
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            seen_reg       <= seen_next;
            ovf_reg        <= ovf_next;
            decl_reg       <= decl_next;
            rem_reg        <= rem_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            if (item_pop)
                out_valid_reg <= res_valid;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (item_pop && res_valid)
        begin
            out_byte_reg <= res_byte;
            out_eom_reg  <= res_eom;
            out_code_reg <= res_code;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.payload_byte   = out_byte_reg;
    assign result.end_of_message = out_eom_reg;
    assign result.is_error       = (out_code_reg != ERR_NONE);
    assign result.error_code     = out_code_reg;

    `MDF_ASSERT_IMP(a_body_has_bytes, clk, rst_n, in_body_reg, rem_reg != '0)
    `MDF_ASSERT_IMP(a_ovf_needs_header, clk, rst_n, ovf_reg, seen_reg)
    `MDF_ASSERT_IMP(a_held_line_mode, clk, rst_n, held_valid_reg || in_body_reg,
                    mode_reg == !held_valid_reg)

endmodule

FILE: rtl/message_deframer.sv
// ---------------------------------------------------------------------------
// message_deframer
// splits a raw byte stream into message payloads, by lines or by
// content-length headers
// ---------------------------------------------------------------------------
// One stream beat is taken per clock and at most one result beat leaves per
// clock, so the sustained rate is one byte per cycle when the result side
// keeps up. A beat accepted from the stream is written into the front
// queue, taken from it by the engine and held in the result register,
// from which its result is offered. The whole update of a byte (line
// tracking, prefix match and the times-ten length step as shift and add)
// is combinational and is registered as the engine takes the beat. In
// newline mode a line byte is held until the next byte of the stream
// arrives, so it leaves one beat late. The queue lets the stream side
// keep going for QUEUE_DEPTH beats while the result side stalls; once it
// is full the stream side is held off until a result beat leaves. The user
// must write framing mode on the cfg channel only while the block is idle,
// not enforced by the block; a write drops any partial line or message.
// ---------------------------------------------------------------------------
module message_deframer
    import mdf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,  // body length limit is 2^LENGTH_BITS-1
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT   // beats between front and engine
)
(
    input  logic          clk,
    input  logic          rst_n,
    mdf_stream_if.sink    stream,
    mdf_result_if.source  message,
    mdf_cfg_if.sink       cfg
);

    // mode writes are always taken
    logic  cfg_we;
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    // front to queue
    logic  q_full;
    logic  q_push;
    item_t q_push_item;

    // queue to engine
    logic  q_pop;
    item_t q_pop_item;
    logic  q_not_empty;

    // classify each incoming byte
    mdf_front u_front (
        .stream    (stream),
        .q_full    (q_full),
        .push      (q_push),
        .push_item (q_push_item)
    );

    // decouples the stream from result back pressure; cleared on a mode write
    mdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (cfg_we),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .not_empty (q_not_empty)
    );

    // framing state and the result register
    mdf_engine #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_mode   (cfg.framing_mode),
        .item_valid (q_not_empty),
        .item       (q_pop_item),
        .item_pop   (q_pop),
        .result     (message)
    );

endmodule
